### sv/xieu_pkg.sv
// ----------------------------------------------------------------------------
// xieu_pkg
// Shared types and opcode and condition codes for the x86 integer execute unit.
// ----------------------------------------------------------------------------
package xieu_pkg;

    localparam int RegCount  = 8;
    localparam int RegAddrW  = 3;
    localparam int DataW     = 32;

    localparam logic [4:0] OP_ADD     = 5'd0;
    localparam logic [4:0] OP_OR      = 5'd1;
    localparam logic [4:0] OP_AND     = 5'd2;
    localparam logic [4:0] OP_SUB     = 5'd3;
    localparam logic [4:0] OP_XOR     = 5'd4;
    localparam logic [4:0] OP_CMP     = 5'd5;
    localparam logic [4:0] OP_TEST    = 5'd6;
    localparam logic [4:0] OP_INC     = 5'd7;
    localparam logic [4:0] OP_DEC     = 5'd8;
    localparam logic [4:0] OP_NEG     = 5'd9;
    localparam logic [4:0] OP_SHR     = 5'd10;
    localparam logic [4:0] OP_MOV     = 5'd11;
    localparam logic [4:0] OP_MOVZX16 = 5'd12;
    localparam logic [4:0] OP_CDQ     = 5'd13;
    localparam logic [4:0] OP_IDIV    = 5'd14;
    localparam logic [4:0] OP_AND8    = 5'd15;
    localparam logic [4:0] OP_TEST8   = 5'd16;
    localparam logic [4:0] OP_NOT8    = 5'd17;
    localparam logic [4:0] OP_SETNZ8  = 5'd18;
    localparam logic [4:0] OP_BRANCH  = 5'd19;

    localparam logic [2:0] COND_B  = 3'd0;
    localparam logic [2:0] COND_AE = 3'd1;
    localparam logic [2:0] COND_E  = 3'd2;
    localparam logic [2:0] COND_NE = 3'd3;
    localparam logic [2:0] COND_L  = 3'd4;
    localparam logic [2:0] COND_GE = 3'd5;
    localparam logic [2:0] COND_LE = 3'd6;
    localparam logic [2:0] COND_G  = 3'd7;

    localparam logic [RegAddrW-1:0] REG_EAX = 3'd0;
    localparam logic [RegAddrW-1:0] REG_EDX = 3'd2;

    localparam logic [31:0] SIGN32 = 32'h8000_0000;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [2:0]  first_reg;
        logic        first_in_memory;
        logic [31:0] memory_value;
        logic [2:0]  second_reg;
        logic        second_is_reg;
        logic [31:0] immediate;
        logic [2:0]  condition;
    } req_t;

    typedef struct packed {
        logic [31:0] result;
        logic        write_memory;
        logic        branch_taken;
        logic        zero_flag;
        logic        sign_flag;
        logic        carry_flag;
        logic        overflow_flag;
        logic        divide_error;
    } rsp_t;

    typedef struct packed {
        logic of;
        logic cf;
        logic sf;
        logic zf;
    } flags_t;

    typedef struct packed {
        logic [31:0]         res;
        flags_t              flags;
        logic                wr_en;
        logic [RegAddrW-1:0] wr_addr;
        logic                wmem;
        logic                taken;
    } alu_out_t;

endpackage

### sv/xieu_regfile.sv
// ----------------------------------------------------------------------------
// xieu_regfile
// Eight-entry register file: two registered read ports, one write port.
// ----------------------------------------------------------------------------
module xieu_regfile
    import xieu_pkg::*;
#(
    parameter int Depth = RegCount,
    parameter int AddrW = RegAddrW
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [AddrW-1:0] rd_a_addr,
    input  logic [AddrW-1:0] rd_b_addr,
    output logic [31:0]      rd_a_data,
    output logic [31:0]      rd_b_data,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [31:0]      wr_data
);

    logic [31:0]      mem [Depth];
    logic [Depth-1:0] vld_reg;
    logic [31:0]      a_data_reg;
    logic [31:0]      b_data_reg;
    logic             a_vld_reg;
    logic             b_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        a_data_reg <= mem[rd_a_addr];
        b_data_reg <= mem[rd_b_addr];
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            a_vld_reg <= vld_reg[rd_a_addr];
            b_vld_reg <= vld_reg[rd_b_addr];
        end
    end

    assign rd_a_data = a_vld_reg ? a_data_reg : '0;
    assign rd_b_data = b_vld_reg ? b_data_reg : '0;

endmodule

### sv/xieu_alu.sv
// ----------------------------------------------------------------------------
// xieu_alu
// Combinational integer operations, flag update and write-back selection.
// ----------------------------------------------------------------------------
module xieu_alu
    import xieu_pkg::*;
(
    input  req_t     req,
    input  logic [31:0] ra,
    input  logic [31:0] rb,
    input  flags_t   flags_in,
    output alu_out_t alu_out
);

    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  a8;
    logic [7:0]  r8;
    logic [32:0] sum33;
    logic [32:0] diff33;
    logic [31:0] res;
    logic [31:0] sh_tmp;
    logic [4:0]  cnt;
    flags_t      fl;
    logic        wr32;
    logic        wr8;
    logic        cdq_wr;
    logic        taken;
    logic        lt;

    always_comb
    begin
        a      = req.first_in_memory ? req.memory_value : ra;
        b      = req.second_is_reg ? rb : req.immediate;
        a8     = req.first_in_memory ? req.memory_value[7:0]
                                     : (req.first_reg[2] ? ra[15:8] : ra[7:0]);
        sum33  = {1'b0, a} + {1'b0, b};
        diff33 = {1'b0, a} - {1'b0, b};
        cnt    = req.immediate[4:0];
        sh_tmp = a >> (cnt - 5'd1);
        lt     = flags_in.sf != flags_in.of;
        res    = '0;
        r8     = '0;
        fl     = flags_in;
        wr32   = 1'b0;
        wr8    = 1'b0;
        cdq_wr = 1'b0;
        taken  = 1'b0;

        case (req.opcode)
            OP_ADD:
            begin
                res   = sum33[31:0];
                fl.cf = sum33[32];
                fl.of = (~(a ^ b) & (a ^ res)) >> 31 != 32'd0;
                wr32  = 1'b1;
            end
            OP_OR, OP_AND, OP_XOR, OP_TEST:
            begin
                res   = (req.opcode == OP_OR)  ? (a | b) :
                        (req.opcode == OP_XOR) ? (a ^ b) : (a & b);
                fl.cf = 1'b0;
                fl.of = 1'b0;
                wr32  = req.opcode != OP_TEST;
            end
            OP_SUB, OP_CMP:
            begin
                res   = diff33[31:0];
                fl.cf = diff33[32];
                fl.of = ((a ^ b) & (a ^ res)) >> 31 != 32'd0;
                wr32  = req.opcode == OP_SUB;
            end
            OP_INC:
            begin
                res   = a + 32'd1;
                fl.of = res == SIGN32;
                wr32  = 1'b1;
            end
            OP_DEC:
            begin
                res   = a - 32'd1;
                fl.of = a == SIGN32;
                wr32  = 1'b1;
            end
            OP_NEG:
            begin
                res   = 32'd0 - a;
                fl.cf = a != 32'd0;
                fl.of = a == SIGN32;
                wr32  = 1'b1;
            end
            OP_SHR:
            begin
                res = a;
                if (cnt != 5'd0)
                begin
                    res   = a >> cnt;
                    fl.cf = sh_tmp[0];
                    if (cnt == 5'd1)
                    begin
                        fl.of = a[31];
                    end
                    wr32 = 1'b1;
                end
            end
            OP_MOV:
            begin
                res  = b;
                wr32 = 1'b1;
            end
            OP_MOVZX16:
            begin
                res  = {16'd0, b[15:0]};
                wr32 = 1'b1;
            end
            OP_CDQ:
            begin
                res    = {32{ra[31]}};
                cdq_wr = 1'b1;
            end
            OP_AND8, OP_TEST8:
            begin
                r8    = a8 & b[7:0];
                fl.cf = 1'b0;
                fl.of = 1'b0;
                wr8   = req.opcode == OP_AND8;
            end
            OP_NOT8:
            begin
                r8  = ~a8;
                wr8 = 1'b1;
            end
            OP_SETNZ8:
            begin
                r8  = {7'd0, ~flags_in.zf};
                wr8 = 1'b1;
            end
            OP_BRANCH:
            begin
                case (req.condition)
                    COND_B:  taken = flags_in.cf;
                    COND_AE: taken = ~flags_in.cf;
                    COND_E:  taken = flags_in.zf;
                    COND_NE: taken = ~flags_in.zf;
                    COND_L:  taken = lt;
                    COND_GE: taken = ~lt;
                    COND_LE: taken = flags_in.zf | lt;
                    default: taken = ~flags_in.zf & ~lt;
                endcase
            end
            default:
            begin
                res = '0;
            end
        endcase

        // flag-setting ops update ZF and SF from the result width
        if (req.opcode inside {OP_ADD, OP_OR, OP_AND, OP_SUB, OP_XOR, OP_CMP, OP_TEST,
                               OP_INC, OP_DEC, OP_NEG} || (req.opcode == OP_SHR && wr32))
        begin
            fl.zf = res == 32'd0;
            fl.sf = res[31];
        end
        if (req.opcode inside {OP_AND8, OP_TEST8})
        begin
            fl.zf = r8 == 8'd0;
            fl.sf = r8[7];
        end

        if (req.opcode inside {OP_AND8, OP_TEST8, OP_NOT8, OP_SETNZ8})
        begin
            if (wr8 && !req.first_in_memory)
            begin
                res = req.first_reg[2] ? {ra[31:16], r8, ra[7:0]} : {ra[31:8], r8};
            end
            else
            begin
                res = {24'd0, r8};
            end
        end

        alu_out.res     = res;
        alu_out.flags   = fl;
        alu_out.wmem    = (wr32 | wr8) & req.first_in_memory;
        alu_out.wr_en   = ((wr32 | wr8) & ~req.first_in_memory) | cdq_wr;
        alu_out.wr_addr = cdq_wr ? REG_EDX :
                          wr8    ? {1'b0, req.first_reg[1:0]} : req.first_reg;
        alu_out.taken   = taken;
    end

endmodule

### sv/xieu_divider.sv
// ----------------------------------------------------------------------------
// xieu_divider
// Unsigned 64-by-32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xieu_divider
    import xieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);

    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic [32:0] sub33;
    logic        qbit;
    logic [31:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[63]};
        sub33    = rem_sh - {1'b0, dvs_reg};
        qbit     = rem_sh >= {1'b0, dvs_reg};
        rem_next = qbit ? sub33[31:0] : rem_sh[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[62:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

### sv/x86_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// x86_integer_execute_unit
// Executes decoded x86 integer operations against a register file and flags.
// ----------------------------------------------------------------------------
// One request is handled at a time. A plain operation is accepted and reads
// the register file in S_IDLE, executes in S_EXEC, then in S_DONE writes back
// and loads the response into the output register, waiting while it is held.
// Signed divide reads the divisor and EDX, then EAX, and unless the divisor is
// zero runs the restoring divider through all 64 bits of the dividend.
// The register file's registered read and single write port set this order.
module x86_integer_execute_unit
    import xieu_pkg::*;
#(
    parameter int Depth = RegCount,
    parameter int AddrW = RegAddrW
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DRD,
        S_DIV,
        S_DONE
    } state_t;

    state_t      state_reg;
    req_t        req_reg;
    flags_t      flags_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    logic [31:0] pend_res_reg;
    flags_t      pend_flags_reg;
    logic        pend_wmem_reg;
    logic        pend_taken_reg;
    logic        pend_derr_reg;
    logic        pend_wr_reg;
    logic [AddrW-1:0] pend_addr_reg;
    logic [31:0] dv_reg;
    logic [31:0] edx_reg;
    logic        qneg_reg;
    logic        nn_reg;
    logic [31:0] edx_wr_reg;

    logic [AddrW-1:0] rd_a_addr;
    logic [AddrW-1:0] rd_b_addr;
    logic [31:0] ra;
    logic [31:0] rb;
    logic        wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [31:0] wr_data;
    alu_out_t    alu_out;
    logic        accept;
    logic        slot_free;
    logic [63:0] num;
    logic [63:0] num_mag;
    logic [31:0] dv_mag;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;
    logic [31:0] div_r;
    logic        div_ovf;
    logic [31:0] q_val;
    logic [31:0] r_val;

    assign accept    = req_valid && !req_stall;
    assign req_stall = state_reg != S_IDLE;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rd_a_addr = req.first_reg;
        rd_b_addr = req.second_reg;
        if (state_reg == S_IDLE)
        begin
            if (req.opcode == OP_CDQ)
            begin
                rd_a_addr = REG_EAX;
            end
            else if (req.opcode inside {OP_AND8, OP_TEST8, OP_NOT8, OP_SETNZ8})
            begin
                rd_a_addr = {1'b0, req.first_reg[1:0]};
            end
            if (req.opcode == OP_IDIV)
            begin
                rd_b_addr = REG_EDX;
            end
        end
        else
        begin
            rd_a_addr = REG_EAX;
        end
    end

    always_comb
    begin
        num       = {edx_reg, ra};
        num_mag   = nn_reg ? (64'd0 - num) : num;
        dv_mag    = dv_reg[31] ? (32'd0 - dv_reg) : dv_reg;
        div_start = state_reg == S_DRD && dv_reg != 32'd0;
        div_ovf   = qneg_reg ? (div_q > 64'h8000_0000) : (div_q > 64'h7FFF_FFFF);
        q_val     = qneg_reg ? (32'd0 - div_q[31:0]) : div_q[31:0];
        r_val     = nn_reg ? (32'd0 - div_r) : div_r;

        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = pend_res_reg;
        if (state_reg == S_DIV && div_done && !div_ovf)
        begin
            wr_en   = 1'b1;
            wr_addr = REG_EAX;
            wr_data = q_val;
        end
        else if (state_reg == S_DONE && slot_free && pend_wr_reg)
        begin
            wr_en   = 1'b1;
            wr_data = (req_reg.opcode == OP_IDIV) ? edx_wr_reg : pend_res_reg;
        end
    end

    xieu_regfile #(
        .Depth (Depth),
        .AddrW (AddrW)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (ra),
        .rd_b_data (rb),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    xieu_alu u_alu (
        .req      (req_reg),
        .ra       (ra),
        .rb       (rb),
        .flags_in (flags_reg),
        .alu_out  (alu_out)
    );

    xieu_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (num_mag),
        .divisor   (dv_mag),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flags_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= req;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    pend_res_reg   <= alu_out.res;
                    pend_flags_reg <= alu_out.flags;
                    pend_wmem_reg  <= alu_out.wmem;
                    pend_taken_reg <= alu_out.taken;
                    pend_derr_reg  <= 1'b0;
                    pend_wr_reg    <= alu_out.wr_en;
                    pend_addr_reg  <= alu_out.wr_addr;
                    dv_reg   <= req_reg.first_in_memory ? req_reg.memory_value : ra;
                    edx_reg  <= rb;
                    nn_reg   <= rb[31];
                    qneg_reg <= rb[31] ^
                        (req_reg.first_in_memory ? req_reg.memory_value[31] : ra[31]);
                    state_reg <= (req_reg.opcode == OP_IDIV) ? S_DRD : S_DONE;
                end
                S_DRD:
                begin
                    pend_flags_reg <= flags_reg;
                    pend_taken_reg <= 1'b0;
                    pend_wmem_reg  <= 1'b0;
                    pend_wr_reg    <= 1'b0;
                    pend_res_reg   <= '0;
                    if (dv_reg == 32'd0)
                    begin
                        pend_derr_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        pend_derr_reg <= div_ovf;
                        pend_res_reg  <= div_ovf ? 32'd0 : q_val;
                        pend_wr_reg   <= !div_ovf;
                        pend_addr_reg <= REG_EDX;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        flags_reg             <= pend_flags_reg;
                        rsp_valid_reg         <= 1'b1;
                        rsp_reg.result        <= pend_res_reg;
                        rsp_reg.write_memory  <= pend_wmem_reg;
                        rsp_reg.branch_taken  <= pend_taken_reg;
                        rsp_reg.zero_flag     <= pend_flags_reg.zf;
                        rsp_reg.sign_flag     <= pend_flags_reg.sf;
                        rsp_reg.carry_flag    <= pend_flags_reg.cf;
                        rsp_reg.overflow_flag <= pend_flags_reg.of;
                        rsp_reg.divide_error  <= pend_derr_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // EDX is written from the remainder, not the quotient held for the response
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_done)
        begin
            edx_wr_reg <= r_val;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted request did not enter execute");

    a_done_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=> rsp_valid_reg)
        else $error("finished request did not load the response");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_DIV || state_reg == S_DONE))
        else $error("register write outside write-back");
`endif

endmodule
